>>> src/lr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Beat formats of both channels, the octant codes and the queue entry that
// travels from the front end to the stepping unit.
// ---------------------------------------------------------------------------
package lr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int MAJ_BITS    = COORD_BITS + 1;   // mirrored coords, signed
	localparam int DEC_BITS    = COORD_BITS + 3;   // decision and increments
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		OCT_0 = 3'd0,
		OCT_1 = 3'd1,
		OCT_2 = 3'd2,
		OCT_3 = 3'd3,
		OCT_4 = 3'd4,
		OCT_5 = 3'd5,
		OCT_6 = 3'd6,
		OCT_7 = 3'd7
	} octant_t;

	typedef struct packed {
		cmd_t                  command;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
	} in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic                  pixel_valid;
		logic                  last_pixel;
	} out_t;

	typedef struct packed {
		cmd_t                        command;
		logic                        vertical;
		octant_t                     octant;
		logic signed [MAJ_BITS-1:0]  cur_major;
		logic signed [MAJ_BITS-1:0]  cur_minor;
		logic signed [MAJ_BITS-1:0]  stop_major;
		logic signed [DEC_BITS-1:0]  decision;
		logic signed [DEC_BITS-1:0]  inc_straight;
		logic signed [DEC_BITS-1:0]  inc_diagonal;
	} entry_t;

	typedef struct packed {
		logic signed [MAJ_BITS-1:0] maj;
		logic signed [MAJ_BITS-1:0] mnr;
	} pair_t;

endpackage
`default_nettype wire

>>> src/lr_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lr_front: command intake and line set-up
// Takes command beats, finds octant, mirrors the endpoints into octant zero
// and builds the queue entry over two register stages.
// ---------------------------------------------------------------------------
module lr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire lr_pkg::in_t   cmd,
	output logic               q_push,
	input  wire logic          q_ready,
	output lr_pkg::entry_t     q_entry
);

	function automatic lr_pkg::pair_t mirror_in(
		input logic signed [lr_pkg::MAJ_BITS-1:0] x,
		input logic signed [lr_pkg::MAJ_BITS-1:0] y,
		input lr_pkg::octant_t                    n
	);
		lr_pkg::pair_t p;
		unique case (n)
			lr_pkg::OCT_0: begin p.maj = x;  p.mnr = y;  end
			lr_pkg::OCT_1: begin p.maj = y;  p.mnr = x;  end
			lr_pkg::OCT_2: begin p.maj = y;  p.mnr = -x; end
			lr_pkg::OCT_3: begin p.maj = -x; p.mnr = y;  end
			lr_pkg::OCT_4: begin p.maj = -x; p.mnr = -y; end
			lr_pkg::OCT_5: begin p.maj = -y; p.mnr = -x; end
			lr_pkg::OCT_6: begin p.maj = -y; p.mnr = x;  end
			lr_pkg::OCT_7: begin p.maj = x;  p.mnr = -y; end
		endcase
		return p;
	endfunction

	// stage 1: raw endpoints and deltas
	logic                              vld_s1;
	lr_pkg::cmd_t                      cmd_s1;
	logic [lr_pkg::COORD_BITS-1:0]     x1_s1, y1_s1, x2_s1, y2_s1;
	logic signed [lr_pkg::MAJ_BITS-1:0] dx_s1, dy_s1;

	// stage 2: magnitudes and octant
	logic                              vld_s2;
	lr_pkg::cmd_t                      cmd_s2;
	logic [lr_pkg::COORD_BITS-1:0]     x1_s2, y1_s2, x2_s2, y2_s2;
	logic [lr_pkg::COORD_BITS-1:0]     ax_s2, ay_s2;
	logic                              xmaj_s2, vert_s2, dyneg_s2;
	lr_pkg::octant_t                   oct_s2;

	logic s2_free, s1_free, adv_s1;

	assign s2_free   = !vld_s2 || q_ready;
	assign adv_s1    = vld_s1 && s2_free;
	assign s1_free   = !vld_s1 || s2_free;
	assign cmd_ready = s1_free;
	assign q_push    = vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_free) vld_s1 <= cmd_valid;
			if (s2_free) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && s1_free) begin
			cmd_s1 <= cmd.command;
			x1_s1  <= cmd.start_x;
			y1_s1  <= cmd.start_y;
			x2_s1  <= cmd.end_x;
			y2_s1  <= cmd.end_y;
			dx_s1  <= $signed({1'b0, cmd.end_x}) - $signed({1'b0, cmd.start_x});
			dy_s1  <= $signed({1'b0, cmd.end_y}) - $signed({1'b0, cmd.start_y});
		end
	end

	// magnitude and octant of the line
	logic signed [lr_pkg::MAJ_BITS-1:0] ax_w, ay_w;
	logic [lr_pkg::COORD_BITS-1:0]      ax_d, ay_d;
	logic                               xmaj_d, dxneg, dyneg;
	lr_pkg::octant_t                    oct_d;

	always_comb begin
		dxneg  = dx_s1[lr_pkg::MAJ_BITS-1];
		dyneg  = dy_s1[lr_pkg::MAJ_BITS-1];
		ax_w   = dxneg ? -dx_s1 : dx_s1;
		ay_w   = dyneg ? -dy_s1 : dy_s1;
		ax_d   = ax_w[lr_pkg::COORD_BITS-1:0];
		ay_d   = ay_w[lr_pkg::COORD_BITS-1:0];
		xmaj_d = ay_d <= ax_d;
		priority if (!dxneg && !dyneg) oct_d = xmaj_d ? lr_pkg::OCT_0 : lr_pkg::OCT_1;
		else if (!dxneg)               oct_d = xmaj_d ? lr_pkg::OCT_7 : lr_pkg::OCT_6;
		else if (!dyneg)               oct_d = xmaj_d ? lr_pkg::OCT_3 : lr_pkg::OCT_2;
		else                           oct_d = xmaj_d ? lr_pkg::OCT_4 : lr_pkg::OCT_5;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s2   <= cmd_s1;
			x1_s2    <= x1_s1;
			y1_s2    <= y1_s1;
			x2_s2    <= x2_s1;
			y2_s2    <= y2_s1;
			ax_s2    <= ax_d;
			ay_s2    <= ay_d;
			xmaj_s2  <= xmaj_d;
			vert_s2  <= (dx_s1 == '0);
			dyneg_s2 <= dyneg;
			oct_s2   <= oct_d;
		end
	end

	// entry set-up: mirrored endpoints and decision terms
	lr_pkg::pair_t                  p1, p2;
	logic [lr_pkg::COORD_BITS-1:0]  dmaj, dmin;
	logic [lr_pkg::DEC_BITS-1:0]    dmin2, dmaj1, dmaj2;

	always_comb begin
		p1    = mirror_in($signed({1'b0, x1_s2}), $signed({1'b0, y1_s2}), oct_s2);
		p2    = mirror_in($signed({1'b0, x2_s2}), $signed({1'b0, y2_s2}), oct_s2);
		dmaj  = xmaj_s2 ? ax_s2 : ay_s2;
		dmin  = xmaj_s2 ? ay_s2 : ax_s2;
		dmin2 = {2'b00, dmin, 1'b0};
		dmaj1 = {3'b000, dmaj};
		dmaj2 = {2'b00, dmaj, 1'b0};

		q_entry.command = cmd_s2;
		if (vert_s2) begin
			// walk from the lower y to the higher y
			q_entry.vertical     = 1'b1;
			q_entry.octant       = lr_pkg::OCT_0;
			q_entry.cur_minor    = $signed({1'b0, x1_s2});
			q_entry.cur_major    = $signed({1'b0, dyneg_s2 ? y2_s2 : y1_s2});
			q_entry.stop_major   = $signed({1'b0, dyneg_s2 ? y1_s2 : y2_s2});
			q_entry.decision     = '0;
			q_entry.inc_straight = '0;
			q_entry.inc_diagonal = '0;
		end else begin
			q_entry.vertical     = 1'b0;
			q_entry.octant       = oct_s2;
			q_entry.cur_major    = p1.maj;
			q_entry.cur_minor    = p1.mnr;
			q_entry.stop_major   = p2.maj;
			q_entry.decision     = $signed(dmin2) - $signed(dmaj1);
			q_entry.inc_straight = $signed(dmin2);
			q_entry.inc_diagonal = $signed(dmin2) - $signed(dmaj2);
		end
	end

endmodule
`default_nettype wire

>>> src/lr_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lr_queue: entry queue between set-up and stepping
// Small register queue; push and pop are independent so either side may stall.
// ---------------------------------------------------------------------------
module lr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                push_ready,
	input  wire lr_pkg::entry_t wdata,
	output logic                pop_valid,
	input  wire logic           pop,
	output lr_pkg::entry_t      rdata
);

	lr_pkg::entry_t                 mem_q [lr_pkg::QUEUE_DEPTH];
	logic [lr_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [lr_pkg::QCNT_BITS-1:0]   count_q;
	logic                           do_push;

	assign push_ready = count_q != lr_pkg::QCNT_BITS'(lr_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push && push_ready;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)     rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lr_pkg::QCNT_BITS'(lr_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule
`default_nettype wire

>>> src/lr_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lr_back: Bresenham stepping unit
// Holds the active line, emits one pixel per entry into an output register.
// ---------------------------------------------------------------------------
module lr_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output logic                q_pop,
	input  wire lr_pkg::entry_t q_entry,
	output logic                pix_valid,
	input  wire logic           pix_ready,
	output lr_pkg::out_t        pix
);

	function automatic lr_pkg::pair_t mirror_out(
		input logic signed [lr_pkg::MAJ_BITS-1:0] ma,
		input logic signed [lr_pkg::MAJ_BITS-1:0] mi,
		input lr_pkg::octant_t                    n
	);
		lr_pkg::pair_t p;   // maj carries x, mnr carries y
		unique case (n)
			lr_pkg::OCT_0: begin p.maj = ma;  p.mnr = mi;  end
			lr_pkg::OCT_1: begin p.maj = mi;  p.mnr = ma;  end
			lr_pkg::OCT_2: begin p.maj = -mi; p.mnr = ma;  end
			lr_pkg::OCT_3: begin p.maj = -ma; p.mnr = mi;  end
			lr_pkg::OCT_4: begin p.maj = -ma; p.mnr = -mi; end
			lr_pkg::OCT_5: begin p.maj = -mi; p.mnr = -ma; end
			lr_pkg::OCT_6: begin p.maj = mi;  p.mnr = -ma; end
			lr_pkg::OCT_7: begin p.maj = ma;  p.mnr = -mi; end
		endcase
		return p;
	endfunction

	logic           active_q;
	lr_pkg::entry_t line_q;     // command member unused in the held line
	logic           out_vld_q;
	lr_pkg::out_t   out_q;

	logic           adv, start, src_active, last;
	lr_pkg::entry_t src;
	lr_pkg::entry_t line_d;
	lr_pkg::pair_t  scr;
	lr_pkg::out_t   out_d;

	assign adv       = q_valid && (!out_vld_q || pix_ready);
	assign q_pop     = adv;
	assign pix_valid = out_vld_q;
	assign pix       = out_q;

	always_comb begin
		start      = q_entry.command == lr_pkg::CMD_START;
		src        = start ? q_entry : line_q;
		src_active = start || active_q;
		last       = src.cur_major == src.stop_major;
		// vertical line: x sits in the minor coordinate, y in the major one
		scr        = mirror_out(src.cur_major, src.cur_minor,
			src.vertical ? lr_pkg::OCT_1 : src.octant);
		if (src_active) begin
			out_d.pixel_x     = scr.maj[lr_pkg::COORD_BITS-1:0];
			out_d.pixel_y     = scr.mnr[lr_pkg::COORD_BITS-1:0];
			out_d.pixel_valid = 1'b1;
			out_d.last_pixel  = last;
		end else begin
			out_d = '0;
		end

		// next state of the held line
		line_d = src;
		if (src_active && !last) begin
			line_d.cur_major = src.cur_major + 1'b1;
			if (!src.vertical && !src.decision[lr_pkg::DEC_BITS-1]) begin
				line_d.decision  = src.decision + src.inc_diagonal;
				line_d.cur_minor = src.cur_minor + 1'b1;
			end else if (!src.vertical) begin
				line_d.decision  = src.decision + src.inc_straight;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				active_q  <= src_active && !last;
				out_vld_q <= 1'b1;
			end else if (pix_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q  <= out_d;
			line_q <= line_d;
		end
	end

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && src_active && last) |=> !active_q)
		else $error("line still active after its last pixel");

	a_more_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && src_active && !last) |=> active_q)
		else $error("line dropped before its last pixel");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_q.pixel_valid) |->
		(out_q.pixel_x == '0 && out_q.pixel_y == '0 && !out_q.last_pixel))
		else $error("invalid pixel beat carries nonzero fields");

endmodule
`default_nettype wire

>>> src/line_rasterizer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// line_rasterizer: eight-octant Bresenham line rasterizer
// Start and step command beats in, one pixel beat out for every command beat.
// ---------------------------------------------------------------------------
// A start beat latches both endpoints and returns the first endpoint as a
// pixel; each step beat returns the next pixel of the line, and the pixel at
// the second endpoint carries last_pixel. Lines with equal x at both ends are
// walked from the lower y to the higher y. A step with no line in progress
// returns a beat with pixel_valid low and all other fields zero; a start while
// a line is in progress drops the old line. Throughput is one command beat and
// one pixel beat per clock while pix_ready stays high. An accepted command beat
// passes through two set-up register stages, the four-entry queue, and the
// output register of the stepping unit on its way to its pixel beat.
module line_rasterizer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	output logic              cmd_ready,
	input  wire lr_pkg::in_t  cmd,
	output logic              pix_valid,
	input  wire logic         pix_ready,
	output lr_pkg::out_t      pix
);

	// front end to queue
	logic           fq_push;
	logic           fq_ready;
	lr_pkg::entry_t fq_entry;

	// queue to stepping unit
	logic           qb_valid;
	logic           qb_pop;
	lr_pkg::entry_t qb_entry;

	// set-up: octant, mirroring into octant zero, decision terms
	lr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_push    (fq_push),
		.q_ready   (fq_ready),
		.q_entry   (fq_entry)
	);

	// decouples set-up from stepping so either side may stall on its own
	lr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fq_push),
		.push_ready (fq_ready),
		.wdata      (fq_entry),
		.pop_valid  (qb_valid),
		.pop        (qb_pop),
		.rdata      (qb_entry)
	);

	// holds the line in progress and emits pixels mapped back to the screen
	lr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_pop     (qb_pop),
		.q_entry   (qb_entry),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

endmodule
`default_nettype wire
